// ----- hw/rtl/waypoint_steering_with_repulsion_assert.svh -----
// Assertion macros shared by the waypoint steering RTL.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef WAYPOINT_STEERING_WITH_REPULSION_ASSERT_SVH
`define WAYPOINT_STEERING_WITH_REPULSION_ASSERT_SVH

// same-cycle implication
`define WSR_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define WSR_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- hw/rtl/wsr_pkg.sv -----
// Package for waypoint steering with repulsion: widths, constants, item types.
// No dependencies.
package wsr_pkg;

  localparam int MAX_OBSTACLES = 8;
  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

  localparam int COORD_W = 15;
  localparam int ANG_W   = 16;
  localparam int PULSE_W = 11;
  localparam int DIST_W  = 11;
  localparam int COUNT_W = 4;
  localparam int SUM_W   = 24;
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 28;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int CORD_W  = 34;
  localparam int SQ_W    = 36;
  localparam int ROOT_W  = 18;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [31:0] REPULSE_NUM = 32'd2560000;
  localparam logic [31:0] OD_MIN      = 32'd256;
  localparam logic [31:0] NEAR_Q      = 32'd230400;
  localparam logic [27:0] TURN_GAIN   = 28'd164709933;
  localparam logic signed [15:0] ERR_LIMIT = 16'sd1043;
  localparam int CORDIC_ITERS = 16;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_FAR   = 2'd1;
  localparam logic [1:0] REG_STOP  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic [2:0]               obstacle_index;
    logic [COORD_W-1:0]       obstacle_x;
    logic [COORD_W-1:0]       obstacle_y;
    logic [COORD_W-1:0]       robot_x;
    logic [COORD_W-1:0]       robot_y;
    logic signed [ANG_W-1:0]  robot_heading;
    logic [COORD_W-1:0]       target_x;
    logic [COORD_W-1:0]       target_y;
  } cmd_t;

  typedef struct packed {
    logic [PULSE_W-1:0] left_pulse;
    logic [PULSE_W-1:0] right_pulse;
    logic [PULSE_W-1:0] direct_left;
    logic [PULSE_W-1:0] direct_right;
  } res_t;

  // atan(2^-i) in 2^-24 turn
  function automatic logic [31:0] cordic_angle(input logic [3:0] i);
    logic [31:0] a;
    unique case (i)
      4'd0:  a = 32'd2097152;
      4'd1:  a = 32'd1238021;
      4'd2:  a = 32'd654136;
      4'd3:  a = 32'd332050;
      4'd4:  a = 32'd166669;
      4'd5:  a = 32'd83416;
      4'd6:  a = 32'd41718;
      4'd7:  a = 32'd20860;
      4'd8:  a = 32'd10430;
      4'd9:  a = 32'd5215;
      4'd10: a = 32'd2608;
      4'd11: a = 32'd1304;
      4'd12: a = 32'd652;
      4'd13: a = 32'd326;
      4'd14: a = 32'd163;
      4'd15: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/waypoint_steering_with_repulsion.sv -----
// Top level of waypoint steering with obstacle repulsion: sequencer, shared multiplier,
// obstacle table, register port. Depends on wsr_pkg, wsr_div, wsr_cordic, wsr_isqrt.
//
// An obstacle-load item is written into the table when accepted and gives no result.
// After a control-step item is accepted, cmd_stall stays high while the sequencer
// squares the distances and visits each used obstacle in states S_OBS, S_OX, S_OY and
// S_CHK, and for an obstacle whose squared distance is in range it adds two passes of the
// one-bit-per-cycle divider. The base work covers up to 29 normalization doublings, 16
// CORDIC steps and 18 square-root steps (a zero steering vector skips the CORDIC); a
// result register held by res_stall also prolongs the stall. The result waits in an
// output register; the next item is taken once the step has placed its result there.
`include "waypoint_steering_with_repulsion_assert.svh"

module waypoint_steering_with_repulsion import wsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_t              cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [4:0] {
    S_IDLE, S_DX, S_DY, S_FAR, S_STOP, S_OBS, S_OX, S_OY, S_CHK,
    S_NUMX, S_DSX, S_DWX, S_NUMY, S_DSY, S_DWY,
    S_ATAN, S_ATW, S_GAIN, S_SQ, S_SQW, S_OUT
  } st_t;

  st_t st;

  logic [COUNT_W-1:0] obstacle_count;
  logic [DIST_W-1:0]  far_distance;
  logic [DIST_W-1:0]  stop_distance;

  logic [COORD_W-1:0] tab_x [MAX_OBSTACLES];
  logic [COORD_W-1:0] tab_y [MAX_OBSTACLES];

  logic [COORD_W-1:0]       rx;
  logic [COORD_W-1:0]       ry;
  logic [ANG_W-1:0]         heading;
  logic signed [15:0]       dx;
  logic signed [15:0]       dy;
  logic [31:0]              d2;
  logic [31:0]              farq;
  logic [31:0]              stopq;
  logic signed [SUM_W-1:0]  sx;
  logic signed [SUM_W-1:0]  sy;
  logic [CNT_W-1:0]         n_q;
  logic [CNT_W-1:0]         idx;
  logic signed [15:0]       ox;
  logic signed [15:0]       oy;
  logic [31:0]              od;
  logic [31:0]              num;
  logic signed [ANG_W-1:0]  err;
  logic [12:0]              mag;
  logic [ROOT_W-1:0]        root_q;

  logic                     accept;
  logic                     cfg_wr;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [MUL_P_W-1:0]       mul_p;
  logic [15:0]              abs_dx;
  logic [15:0]              abs_dy;
  logic [15:0]              abs_ox;
  logic [15:0]              abs_oy;
  logic signed [16:0]       err_x;
  logic [16:0]              abs_err;
  logic [14:0]              far16;
  logic [14:0]              stop16;
  logic signed [15:0]       dx_c;
  logic signed [15:0]       dy_c;
  logic signed [15:0]       ox_c;
  logic signed [15:0]       oy_c;
  logic [CNT_W-1:0]         n_c;

  logic                     div_start;
  logic                     div_done;
  logic [31:0]              quot;
  logic signed [SUM_W-1:0]  q_s;
  logic                     cor_start;
  logic                     cor_done;
  logic [ANG_W-1:0]         angle;
  logic                     sq_start;
  logic                     sq_done;
  logic [ROOT_W-1:0]        root;
  logic [SQ_W-1:0]          rad;

  logic [12:0]              mag_c;
  logic signed [12:0]       turn;
  logic [8:0]               speed;
  logic signed [12:0]       pl;
  logic signed [12:0]       pr;
  logic [PULSE_W-1:0]       pl_c;
  logic [PULSE_W-1:0]       pr_c;
  logic [PULSE_W-1:0]       fwd;
  logic [PULSE_W-1:0]       dl;
  logic [PULSE_W-1:0]       dr;
  logic                     pulse_ok;
  logic                     direct_ok;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cmd_stall = (st != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    unique case (paddr[3:2])
      REG_COUNT: prdata = DATA_W'(obstacle_count);
      REG_FAR:   prdata = DATA_W'(far_distance);
      REG_STOP:  prdata = DATA_W'(stop_distance);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_count <= '0;
      far_distance   <= DIST_W'(80);
      stop_distance  <= DIST_W'(5);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_COUNT: obstacle_count <= pwdata[COUNT_W-1:0];
        REG_FAR:   far_distance   <= pwdata[DIST_W-1:0];
        REG_STOP:  stop_distance  <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.opcode == OP_LOAD &&
        {1'b0, cmd.obstacle_index} < 4'(MAX_OBSTACLES)) begin
      tab_x[IDX_W'(cmd.obstacle_index)] <= cmd.obstacle_x;
      tab_y[IDX_W'(cmd.obstacle_index)] <= cmd.obstacle_y;
    end
  end

  always_comb begin
    dx_c   = $signed({1'b0, cmd.target_x}) - $signed({1'b0, cmd.robot_x});
    dy_c   = $signed({1'b0, cmd.target_y}) - $signed({1'b0, cmd.robot_y});
    ox_c   = $signed({1'b0, rx}) - $signed({1'b0, tab_x[idx[IDX_W-1:0]]});
    oy_c   = $signed({1'b0, ry}) - $signed({1'b0, tab_y[idx[IDX_W-1:0]]});
    n_c    = ({1'b0, obstacle_count} > 5'(MAX_OBSTACLES)) ?
             CNT_W'(MAX_OBSTACLES) : CNT_W'(obstacle_count);
    abs_dx = dx[15] ? 16'(-dx) : 16'(dx);
    abs_dy = dy[15] ? 16'(-dy) : 16'(dy);
    abs_ox = ox[15] ? 16'(-ox) : 16'(ox);
    abs_oy = oy[15] ? 16'(-oy) : 16'(oy);
    err_x  = {err[ANG_W-1], err};
    abs_err = err_x[16] ? 17'(-err_x) : 17'(err_x);
    far16  = {far_distance, 4'd0};
    stop16 = {stop_distance, 4'd0};
    q_s    = SUM_W'(quot);
    rad    = (SQ_W'(d2) << 4) + (SQ_W'(d2) << 3) + SQ_W'(d2);
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st)
      S_DX:   begin mul_a = 17'(abs_dx); mul_b = 28'(abs_dx); end
      S_DY:   begin mul_a = 17'(abs_dy); mul_b = 28'(abs_dy); end
      S_FAR:  begin mul_a = 17'(far16);  mul_b = 28'(far16);  end
      S_STOP: begin mul_a = 17'(stop16); mul_b = 28'(stop16); end
      S_OX:   begin mul_a = 17'(abs_ox); mul_b = 28'(abs_ox); end
      S_OY:   begin mul_a = 17'(abs_oy); mul_b = 28'(abs_oy); end
      S_NUMX: begin mul_a = 17'(abs_ox); mul_b = 28'(REPULSE_NUM); end
      S_NUMY: begin mul_a = 17'(abs_oy); mul_b = 28'(REPULSE_NUM); end
      S_GAIN: begin mul_a = abs_err;     mul_b = TURN_GAIN; end
      default: ;
    endcase
  end
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  assign div_start = (st == S_DSX) || (st == S_DSY);
  assign cor_start = (st == S_ATAN);
  assign sq_start  = (st == S_SQ);

  wsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (od),
    .done  (div_done),
    .quot  (quot)
  );

  wsr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .xin   (sx),
    .yin   (sy),
    .done  (cor_done),
    .angle (angle)
  );

  wsr_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (rad),
    .done     (sq_done),
    .root     (root)
  );

  // result formation
  always_comb begin
    mag_c = (mag > 13'd500) ? 13'd500 : mag;
    if (d2 < NEAR_Q && mag_c > 13'd100) mag_c = mag_c >> 1;
    turn  = err[ANG_W-1] ? -$signed(mag_c) : $signed(mag_c);
    speed = ((root_q >> 4) > ROOT_W'(300)) ? 9'd300 : 9'(root_q >> 4);
    if (d2 < stopq) speed = '0;
    pl = 13'sd1500 - $signed({4'd0, speed}) + turn;
    pr = 13'sd1500 + $signed({4'd0, speed}) + turn;
    pl_c = (pl < 13'sd1000) ? 11'd1000 : (pl > 13'sd2000) ? 11'd2000 : pl[PULSE_W-1:0];
    pr_c = (pr < 13'sd1000) ? 11'd1000 : (pr > 13'sd2000) ? 11'd2000 : pr[PULSE_W-1:0];
    fwd  = (d2 > farq) ? 11'd200 : 11'd80;
    if (err > ERR_LIMIT) begin
      dl = 11'd1500 - fwd;
      dr = 11'd1620;
    end else if (err < -ERR_LIMIT) begin
      dl = 11'd1620;
      dr = 11'd1500 - fwd;
    end else begin
      dl = 11'd1500 + fwd;
      dr = 11'd1500 + fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      res_valid <= 1'b0;
      idx       <= '0;
      n_q       <= '0;
    end else begin
      if (res_valid && !res_stall && st != S_OUT) res_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (accept && cmd.opcode == OP_STEP) begin
            rx      <= cmd.robot_x;
            ry      <= cmd.robot_y;
            heading <= cmd.robot_heading;
            dx      <= dx_c;
            dy      <= dy_c;
            sx      <= SUM_W'(dx_c);
            sy      <= SUM_W'(dy_c);
            n_q     <= n_c;
            idx     <= '0;
            st      <= S_DX;
          end
        end
        S_DX:   begin d2 <= mul_p[31:0];      st <= S_DY;   end
        S_DY:   begin d2 <= d2 + mul_p[31:0]; st <= S_FAR;  end
        S_FAR:  begin farq <= mul_p[31:0];    st <= S_STOP; end
        S_STOP: begin stopq <= mul_p[31:0];   st <= S_OBS;  end
        S_OBS: begin
          if (idx == n_q) begin
            st <= S_ATAN;
          end else begin
            ox <= ox_c;
            oy <= oy_c;
            st <= S_OX;
          end
        end
        S_OX: begin od <= mul_p[31:0];      st <= S_OY;  end
        S_OY: begin od <= od + mul_p[31:0]; st <= S_CHK; end
        S_CHK: begin
          if (od > OD_MIN && od < REPULSE_NUM) begin
            st <= S_NUMX;
          end else begin
            idx <= idx + CNT_W'(1);
            st  <= S_OBS;
          end
        end
        S_NUMX: begin num <= mul_p[31:0]; st <= S_DSX; end
        S_DSX:  st <= S_DWX;
        S_DWX: begin
          if (div_done) begin
            sx <= ox[15] ? sx - q_s : sx + q_s;
            st <= S_NUMY;
          end
        end
        S_NUMY: begin num <= mul_p[31:0]; st <= S_DSY; end
        S_DSY:  st <= S_DWY;
        S_DWY: begin
          if (div_done) begin
            sy  <= oy[15] ? sy - q_s : sy + q_s;
            idx <= idx + CNT_W'(1);
            st  <= S_OBS;
          end
        end
        S_ATAN: st <= S_ATW;
        S_ATW: begin
          if (cor_done) begin
            err <= $signed(angle - heading);
            st  <= S_GAIN;
          end
        end
        S_GAIN: begin mag <= mul_p[44:32]; st <= S_SQ; end
        S_SQ:   st <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            root_q <= root;
            st     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res.left_pulse   <= pl_c;
            res.right_pulse  <= pr_c;
            res.direct_left  <= dl;
            res.direct_right <= dr;
            res_valid        <= 1'b1;
            st               <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign pulse_ok  = res.left_pulse >= 11'd1000 && res.left_pulse <= 11'd2000 &&
                     res.right_pulse >= 11'd1000 && res.right_pulse <= 11'd2000;
  assign direct_ok = res.direct_left == 11'd1620 || res.direct_right == 11'd1620 ||
                     res.direct_left == res.direct_right;

  `WSR_ASSERT_NOW(a_pulse_range, res_valid, pulse_ok, "pulse out of range")
  `WSR_ASSERT_NOW(a_direct_shape, res_valid, direct_ok, "bad direct command")
  `WSR_ASSERT_NEXT(a_load_quick, accept && cmd.opcode == OP_LOAD, st == S_IDLE, "load left idle")
  `WSR_ASSERT_NOW(a_idx_bound, st == S_OBS, idx <= n_q && n_q <= CNT_W'(MAX_OBSTACLES), "idx overrun")

endmodule

// ----- hw/rtl/wsr_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on wsr_pkg.
module wsr_div import wsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        active;
  logic [32:0] rem_sh;
  logic        fits;

  always_comb begin
    rem_sh = {rem, quot[31]};
    fits   = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem    <= '0;
        quot   <= num;
        cnt    <= 6'd32;
        active <= 1'b1;
      end else if (active) begin
        rem  <= fits ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
        quot <= {quot[30:0], fits};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/wsr_isqrt.sv -----
// Integer square root, two radicand bits per cycle.
// Depends on wsr_pkg.
module wsr_isqrt import wsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [SQ_W-1:0] n;
  logic [SQ_W-1:0] r;
  logic [SQ_W-1:0] b;
  logic [SQ_W-1:0] t;
  logic [4:0]      cnt;
  logic            active;

  assign t    = r + b;
  assign root = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n      <= radicand;
        r      <= '0;
        b      <= SQ_W'(1) << (SQ_W - 2);
        cnt    <= 5'(SQ_W / 2);
        active <= 1'b1;
      end else if (active) begin
        if (n >= t) begin
          n <= n - t;
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b   <= b >> 2;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/wsr_cordic.sv -----
// Vectoring CORDIC atan2 with normalization, one step per cycle.
// Depends on wsr_pkg.
module wsr_cordic import wsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] xin,
  input  logic signed [SUM_W-1:0] yin,
  output logic                    done,
  output logic [ANG_W-1:0]        angle
);

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT} cst_t;

  cst_t                    st;
  logic signed [CORD_W-1:0] x;
  logic signed [CORD_W-1:0] y;
  logic [31:0]              z;
  logic [3:0]               i;
  logic signed [CORD_W-1:0] xe;
  logic signed [CORD_W-1:0] ye;
  logic [CORD_W-1:0]        ax;
  logic [CORD_W-1:0]        ay;
  logic [CORD_W-1:0]        m;
  logic signed [CORD_W-1:0] shx;
  logic signed [CORD_W-1:0] shy;
  logic signed [CORD_W-1:0] x_next;
  logic signed [CORD_W-1:0] y_next;
  logic [31:0]              z_next;
  logic [31:0]              zr;

  always_comb begin
    xe  = CORD_W'(xin);
    ye  = CORD_W'(yin);
    ax  = x[CORD_W-1] ? CORD_W'(-x) : CORD_W'(x);
    ay  = y[CORD_W-1] ? CORD_W'(-y) : CORD_W'(y);
    m   = (ax > ay) ? ax : ay;
    shx = y >>> i;
    shy = x >>> i;
    if (!y[CORD_W-1]) begin
      x_next = x + shx;
      y_next = y - shy;
      z_next = z + cordic_angle(i);
    end else begin
      x_next = x - shx;
      y_next = y + shy;
      z_next = z - cordic_angle(i);
    end
    zr = z_next + 32'd128;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        C_IDLE: begin
          if (start) begin
            if (xin == '0 && yin == '0) begin
              angle <= '0;
              done  <= 1'b1;
            end else begin
              x  <= xin[SUM_W-1] ? -xe : xe;
              y  <= xin[SUM_W-1] ? -ye : ye;
              z  <= xin[SUM_W-1] ? 32'd8388608 : 32'd0;
              st <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (m < (CORD_W'(1) << 29)) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            i  <= '0;
            st <= C_ROT;
          end
        end
        C_ROT: begin
          x <= x_next;
          y <= y_next;
          z <= z_next;
          i <= i + 4'd1;
          if (i == 4'(CORDIC_ITERS - 1)) begin
            angle <= zr[23:8];
            done  <= 1'b1;
            st    <= C_IDLE;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end

endmodule
